FILE: hdl/apu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_pkg
// Shared widths, reset values and register codes of the parameter update block
// ----------------------------------------------------------------------------
package apu_pkg;

  localparam int IDX_W       = 12;
  localparam int VAL_W       = 32;
  localparam int STEP_W      = 16;
  localparam int EPS_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 48;

  localparam int ELEMENTS_DEF = 4096;

  // divider: 64-bit dividend, divisor up to 33 bits shifted left by 8
  localparam int DIV_NW_DEF = 64;
  localparam int DIV_DW_DEF = 41;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  localparam logic [31:0] LR_RST  = 32'd4294967;
  localparam logic [31:0] B1_RST  = 32'd3865470566;
  localparam logic [31:0] B2_RST  = 32'd4290672329;
  localparam logic [23:0] EPS_RST = 24'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE  = 2'd0,
    REG_FIRST_DECAY    = 2'd1,
    REG_SECOND_DECAY   = 2'd2,
    REG_STABILITY_TERM = 2'd3
  } cfg_reg_t;

endpackage

FILE: hdl/apu_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_isqrt
// Iterative integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module apu_isqrt
  import apu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, x_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[61:0], 2'b00};
      rem_r  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_r <= {root_r[30:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hdl/apu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_div
// Restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module apu_div
  import apu_pkg::*;
#(
  parameter int NW = DIV_NW_DEF,
  parameter int DW = DIV_DW_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, num_r[NW-1]};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], ge};
      rem_r <= ge ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

FILE: hdl/adam_parameter_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_parameter_update_top
// Adam optimiser step for one parameter per transfer, moments kept in RAM
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : one transfer per parameter (index, value, gradient, step number).
//  out_* : one transfer per input, updated value and echoed index in tdata,
//          saturation flag in tuser.
//  cfg_* : register writes, always ready, to be issued while idle.
// One item is worked on at a time; in_tready is high only when idle.
// With the step number unchanged, out_tvalid rises once the item has passed
// index reduction (only when ELEMENTS is below 4096), a RAM read, the multiply
// states M1 to M8 on the shared multiplier, the square root, the 64-bit
// divider and the load of the output register; in_tready returns together
// with out_tvalid. A changed, nonzero step number first raises each beta to
// the power t by square-and-multiply, one pass per bit of t, then computes
// the corrected rate with a root, a multiply and a divide.
// After reset a clearing pass zeroes both moment RAMs, one entry a cycle,
// with in_tready low. A stalled result waits in the output register; the
// block can take the next item meanwhile but will not finish it until the
// held result has been transferred.
// ----------------------------------------------------------------------------
module adam_parameter_update_top
  import apu_pkg::*;
#(
  parameter int ELEMENTS = ELEMENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [11:0] element_index, [43:12] param_value, [75:44] gradient,
  // [91:76] step_number, [95:92] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] updated_value, [43:32] result_index, [47:44] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] saturated
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam bit NEED_RED = (ELEMENTS < (1 << IDX_W));
  localparam logic [28:0] ELEM_C = 29'(ELEMENTS);
  localparam logic [AW-1:0] CLR_LAST = AW'(ELEMENTS - 1);

  typedef enum logic [20:0] {
    S_CLR   = 21'h000001,
    S_IDLE  = 21'h000002,
    S_PW1   = 21'h000004,
    S_PW2   = 21'h000008,
    S_PW3   = 21'h000010,
    S_RSQ   = 21'h000020,
    S_RMUL  = 21'h000040,
    S_RDIV  = 21'h000080,
    S_RED   = 21'h000100,
    S_RD    = 21'h000200,
    S_M1    = 21'h000400,
    S_M2    = 21'h000800,
    S_M3    = 21'h001000,
    S_M4    = 21'h002000,
    S_M5    = 21'h004000,
    S_M6    = 21'h008000,
    S_M7    = 21'h010000,
    S_M8    = 21'h020000,
    S_SQ    = 21'h040000,
    S_DV    = 21'h080000,
    S_DONE  = 21'h100000
  } state_t;

  localparam state_t MOM_FIRST = NEED_RED ? S_RED : S_RD;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] lr_r, b1_r, b2_r;
  logic [23:0] eps_r;

  // item registers
  logic [IDX_W-1:0]  idx_in_r, red_r;
  logic [3:0]        red_cnt_r;
  logic signed [31:0] p_r, g_r;
  logic [STEP_W-1:0] cached_r;
  logic [31:0]       rate_r;

  // power and rate
  logic [32:0]       acc_r;
  logic [31:0]       base_r;
  logic [STEP_W-1:0] e_r;
  logic              psel_r;
  logic [32:0]       den_r;

  // moment update
  logic signed [65:0] sum_r;
  logic signed [31:0] m_r;
  logic [62:0]        g2_r;
  logic [63:0]        vacc_r;
  logic [32:0]        q_r;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic               mul_en;
  logic signed [67:0] prod_r;

  // memories
  logic [31:0] m1_mem [ELEMENTS];
  logic [63:0] m2_mem [ELEMENTS];
  logic [31:0] rd1_r;
  logic [63:0] rd2_r;
  logic [AW-1:0] clr_r;
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_re;
  logic [31:0]   m_wd;
  logic [63:0]   v_wd;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_sat_r;

  // iterative units
  logic        sq_start, sq_done;
  logic [63:0] sq_in;
  logic [31:0] sq_root;
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_q;
  logic [40:0] dv_den;

  // input fields
  logic [IDX_W-1:0]  in_idx;
  logic [31:0]       in_p, in_g;
  logic [STEP_W-1:0] in_step;
  logic              in_acc;

  // combinational helpers
  logic [32:0] c1, c2, sq_q, den_q;
  logic [63:0] pow_arg, v_new;
  logic signed [65:0] m_full;
  logic [32:0] m_ext, m_abs, denom;
  logic [28:0] cand;
  logic signed [34:0] res;
  logic [31:0] res_sat;
  logic        res_ovf;

  assign in_idx  = in_tdata[11:0];
  assign in_p    = in_tdata[43:12];
  assign in_g    = in_tdata[75:44];
  assign in_step = in_tdata[91:76];
  assign in_acc  = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  always_comb begin
    c1      = ONE_Q32 - {1'b0, b1_r};
    c2      = ONE_Q32 - {1'b0, b2_r};
    sq_q    = ONE_Q32 - acc_r;
    den_q   = (acc_r == ONE_Q32) ? 33'd1 : sq_q;
    // b2^t of zero would give an argument of 2^64, clamped
    pow_arg = (acc_r == '0) ? '1 : {sq_q[31:0], 32'h0};
    v_new   = vacc_r + {31'h0, prod_r[64:32]};
    m_full  = sum_r + prod_r[65:0];
    m_ext   = {m_r[31], m_r};
    m_abs   = m_r[31] ? (~m_ext + 33'd1) : m_ext;
    denom   = {1'b0, sq_root} + {9'h0, eps_r};
    if (denom == '0) begin
      denom = 33'd1;
    end
    cand    = ELEM_C << red_cnt_r;
    res     = m_r[31] ? ({{3{p_r[31]}}, p_r} + {2'b00, q_r})
                      : ({{3{p_r[31]}}, p_r} - {2'b00, q_r});
    res_ovf = (res[34:31] != 4'b0000) && (res[34:31] != 4'b1111);
    if (!res_ovf) begin
      res_sat = res[31:0];
    end else if (res[34]) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = 32'h7FFF_FFFF;
    end
  end

  assign mul_p = mul_a * mul_b;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    sq_in     = '0;
    dv_start  = 1'b0;
    dv_num    = '0;
    dv_den    = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_step != cached_r && in_step != '0) begin
            state_nxt = S_PW1;
          end else begin
            state_nxt = MOM_FIRST;
          end
        end
      end
      S_PW1: begin
        mul_en    = 1'b1;
        mul_a     = {1'b0, acc_r};
        mul_b     = {2'b00, base_r};
        state_nxt = S_PW2;
      end
      S_PW2: begin
        mul_en    = 1'b1;
        mul_a     = {2'b00, base_r};
        mul_b     = {2'b00, base_r};
        state_nxt = S_PW3;
      end
      S_PW3: begin
        if (e_r[STEP_W-1:1] != '0 || !psel_r) begin
          state_nxt = S_PW1;
        end else begin
          sq_start  = 1'b1;
          sq_in     = pow_arg;
          state_nxt = S_RSQ;
        end
      end
      S_RSQ: begin
        if (sq_done) begin
          mul_en    = 1'b1;
          mul_a     = {2'b00, lr_r};
          mul_b     = {2'b00, sq_root};
          state_nxt = S_RMUL;
        end
      end
      S_RMUL: begin
        dv_start  = 1'b1;
        dv_num    = prod_r[63:0];
        dv_den    = {8'h0, den_r};
        state_nxt = S_RDIV;
      end
      S_RDIV: begin
        if (dv_done) begin
          state_nxt = MOM_FIRST;
        end
      end
      S_RED: begin
        if (red_cnt_r == '0) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_M1;
      end
      S_M1: begin
        mul_en    = 1'b1;
        mul_a     = {{2{rd1_r[31]}}, rd1_r};
        mul_b     = {2'b00, b1_r};
        state_nxt = S_M2;
      end
      S_M2: begin
        mul_en    = 1'b1;
        mul_a     = {{2{g_r[31]}}, g_r};
        mul_b     = {1'b0, c1};
        state_nxt = S_M3;
      end
      S_M3: begin
        mul_en    = 1'b1;
        mul_a     = {{2{g_r[31]}}, g_r};
        mul_b     = {{2{g_r[31]}}, g_r};
        state_nxt = S_M4;
      end
      S_M4: begin
        mul_en    = 1'b1;
        mul_a     = {2'b00, rd2_r[63:32]};
        mul_b     = {2'b00, b2_r};
        state_nxt = S_M5;
      end
      S_M5: begin
        mul_en    = 1'b1;
        mul_a     = {2'b00, rd2_r[31:0]};
        mul_b     = {2'b00, b2_r};
        state_nxt = S_M6;
      end
      S_M6: begin
        mul_en    = 1'b1;
        mul_a     = {3'b000, g2_r[62:32]};
        mul_b     = {1'b0, c2};
        state_nxt = S_M7;
      end
      S_M7: begin
        mul_en    = 1'b1;
        mul_a     = {2'b00, g2_r[31:0]};
        mul_b     = {1'b0, c2};
        state_nxt = S_M8;
      end
      S_M8: begin
        mem_we    = 1'b1;
        sq_start  = 1'b1;
        sq_in     = v_new;
        mul_en    = 1'b1;
        mul_a     = {2'b00, rate_r};
        mul_b     = {1'b0, m_abs};
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (sq_done) begin
          dv_start  = 1'b1;
          dv_num    = prod_r[63:0];
          dv_den    = {denom, 8'h0};
          state_nxt = S_DV;
        end
      end
      S_DV: begin
        if (dv_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cached_r    <= '0;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
      lr_r        <= LR_RST;
      b1_r        <= B1_RST;
      b2_r        <= B2_RST;
      eps_r       <= EPS_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (in_acc && in_step != cached_r) begin
        cached_r <= in_step;
        if (in_step == '0) begin
          rate_r <= '0;
        end
      end
      if (state_r == S_RDIV && dv_done) begin
        rate_r <= (dv_q[63:32] != '0) ? 32'hFFFF_FFFF : dv_q[31:0];
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_LEARNING_RATE:  lr_r  <= cfg_data;
          REG_FIRST_DECAY:    b1_r  <= cfg_data;
          REG_SECOND_DECAY:   b2_r  <= cfg_data;
          REG_STABILITY_TERM: eps_r <= cfg_data[EPS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_p;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_in_r  <= in_idx;
          red_r     <= in_idx;
          red_cnt_r <= 4'(IDX_W - 1);
          p_r       <= in_p;
          g_r       <= in_g;
          acc_r     <= ONE_Q32;
          base_r    <= b1_r;
          e_r       <= in_step;
          psel_r    <= 1'b0;
        end
      end
      S_PW2: begin
        if (e_r[0]) begin
          acc_r <= prod_r[64:32];
        end
      end
      S_PW3: begin
        // first power done: keep its complement, start on the second beta
        if (e_r[STEP_W-1:1] == '0 && !psel_r) begin
          den_r  <= den_q;
          acc_r  <= ONE_Q32;
          base_r <= b2_r;
          e_r    <= cached_r;
          psel_r <= 1'b1;
        end else begin
          base_r <= prod_r[63:32];
          e_r    <= e_r >> 1;
        end
      end
      S_RED: begin
        if ({17'h0, red_r} >= cand) begin
          red_r <= red_r - cand[IDX_W-1:0];
        end
        red_cnt_r <= red_cnt_r - 4'd1;
      end
      S_M2: sum_r  <= prod_r[65:0];
      S_M3: m_r    <= m_full[63:32];
      S_M4: g2_r   <= prod_r[62:0];
      S_M5: vacc_r <= prod_r[63:0];
      S_M6: vacc_r <= vacc_r + {32'h0, prod_r[63:32]};
      S_M7: vacc_r <= vacc_r + prod_r[63:0];
      S_DV: begin
        if (dv_done) begin
          q_r <= (dv_q[63:33] != '0 || (dv_q[32] && dv_q[31:0] != '0))
                 ? ONE_Q32 : dv_q[32:0];
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {4'h0, idx_in_r, res_sat};
          out_sat_r  <= res_ovf;
        end
      end
      default: ;
    endcase
  end

  // moment RAMs, one read-modify-write per item
  assign mem_addr = (state_r == S_CLR) ? clr_r : AW'(red_r);
  assign m_wd     = (state_r == S_CLR) ? '0 : m_r;
  assign v_wd     = (state_r == S_CLR) ? '0 : v_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      m1_mem[mem_addr] <= m_wd;
      m2_mem[mem_addr] <= v_wd;
    end
    if (mem_re) begin
      rd1_r <= m1_mem[mem_addr];
      rd2_r <= m2_mem[mem_addr];
    end
  end

  apu_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  apu_div #(
    .NW (DIV_NW_DEF),
    .DW (DIV_DW_DEF)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (dv_den),
    .done     (dv_done),
    .quotient (dv_q)
  );

endmodule

FILE: hdl/apu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_checker
// Port-level checks of the parameter update block, bound to the top level
// ----------------------------------------------------------------------------
module apu_checker
  import apu_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the clearing pass keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during clearing pass");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

endmodule

bind adam_parameter_update_top apu_checker u_apu_checker (.*);
